// File: src/stroke_repeat_controller_defines.svh
// assertion macros for the stroke_repeat_controller rtl file
`ifndef STROKE_REPEAT_CONTROLLER_DEFINES_SVH
`define STROKE_REPEAT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define SRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define SRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/srctl_pkg.sv
package srctl_pkg;

    localparam int ACT_W   = 3;
    localparam int DELAY_W = 16;
    localparam int SINCE_W = 17;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [ACT_W-1:0] {
        OP_PRESS      = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_CANCEL_KEY = 3'd2,
        OP_CANCEL_ALL = 3'd3,
        OP_TRIGGER    = 3'd4,
        OP_TICK       = 3'd5
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_DELAY = 2'd0,
        REG_REPEAT_DELAY  = 2'd1,
        REG_FORGET_SPAN   = 2'd2
    } t_cfg_reg;

    localparam logic [SINCE_W-1:0] SINCE_MAX = 17'h1FFFF;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd300;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd100;
    localparam logic [DELAY_W-1:0] FORGET_SPAN_RST   = 16'd250;

endpackage

// File: src/srctl_out_buf.sv
module srctl_out_buf
    import srctl_pkg::*;
#(
    parameter int DATA_W = 67
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_skid_valid;
    logic              n_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    logic [DATA_W-1:0] n_skid_data;
    logic              w_pop;

    assign w_pop   = r_valid & i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid      = r_valid;
        n_data       = r_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_data       = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid || w_pop) begin
                n_valid = 1'b1;
                n_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end else if (w_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_data      <= n_data;
        r_skid_data <= n_skid_data;
    end

endmodule

// File: src/stroke_repeat_controller.sv
// Chord autorepeat controller. Each input transaction is either a chord event
// (press, release, cancel key, cancel all, trigger), which is forwarded as one
// result transaction, or a one-millisecond tick, which advances the release
// timer and the repeat countdown and yields a trigger carrying the pressed
// chord when the countdown expires. Opcodes 6 and 7 are dropped. One
// transaction is taken every clock cycle unless the input stalls, and its
// result is registered. Results queue in a two-entry output buffer, and the
// input stalls only while both entries hold results not yet taken. The
// delay and forget-span registers may only be written while the block is idle.
`include "stroke_repeat_controller_defines.svh"

module stroke_repeat_controller
    import srctl_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ACT_W-1:0]     i_opcode,
    input  logic [KEY_BITS-1:0]  i_key_state,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ACT_W-1:0]     o_out_action,
    output logic [KEY_BITS-1:0]  o_out_keys
);

    localparam int RES_W = ACT_W + KEY_BITS;

    logic [DELAY_W-1:0]  r_initial_delay;
    logic [DELAY_W-1:0]  r_repeat_delay;
    logic [DELAY_W-1:0]  r_forget_span;

    logic [KEY_BITS-1:0] r_pressed;
    logic [KEY_BITS-1:0] n_pressed;
    logic [KEY_BITS-1:0] r_released;
    logic [KEY_BITS-1:0] n_released;
    logic                r_repeating;
    logic                n_repeating;
    logic                r_last_press;
    logic                n_last_press;
    logic [SINCE_W-1:0]  r_since;
    logic [SINCE_W-1:0]  n_since;
    logic [DELAY_W-1:0]  r_countdown;
    logic [DELAY_W-1:0]  n_countdown;

    logic                w_accept;
    logic                w_full;
    logic                w_res_valid;
    logic [ACT_W-1:0]    w_res_action;
    logic [KEY_BITS-1:0] w_res_keys;
    logic [RES_W-1:0]    w_out_data;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid & o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay <= INITIAL_DELAY_RST;
            r_repeat_delay  <= REPEAT_DELAY_RST;
            r_forget_span   <= FORGET_SPAN_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_INITIAL_DELAY: r_initial_delay <= i_cfg_wdata;
                REG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg_wdata;
                REG_FORGET_SPAN:   r_forget_span   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pressed    = r_pressed;
        n_released   = r_released;
        n_repeating  = r_repeating;
        n_last_press = r_last_press;
        n_since      = r_since;
        n_countdown  = r_countdown;
        w_res_valid  = 1'b0;
        w_res_action = i_opcode;
        w_res_keys   = i_key_state;
        if (w_accept) begin
            case (t_opcode'(i_opcode))
                OP_PRESS: begin
                    w_res_valid  = 1'b1;
                    n_repeating  = 1'b0;
                    n_last_press = 1'b1;
                    n_pressed    = i_key_state;
                    if (r_since > {1'b0, r_forget_span}) begin
                        n_released = '0;
                    end else if (i_key_state == r_released) begin
                        n_repeating = 1'b1;
                        n_countdown = r_initial_delay;
                    end
                end
                OP_RELEASE: begin
                    w_res_valid = 1'b1;
                    n_repeating = 1'b0;
                    if (r_last_press) begin
                        n_last_press = 1'b0;
                        n_released   = r_pressed;
                        n_since      = '0;
                    end
                end
                OP_CANCEL_KEY, OP_CANCEL_ALL: begin
                    w_res_valid  = 1'b1;
                    n_repeating  = 1'b0;
                    n_last_press = 1'b0;
                    n_released   = '0;
                end
                OP_TRIGGER: begin
                    w_res_valid = 1'b1;
                end
                OP_TICK: begin
                    if (r_since != SINCE_MAX) begin
                        n_since = r_since + 1'b1;
                    end
                    if (r_repeating) begin
                        if (r_countdown <= 16'd1) begin
                            n_countdown  = r_repeat_delay;
                            w_res_valid  = 1'b1;
                            w_res_action = OP_TRIGGER;
                            w_res_keys   = r_pressed;
                        end else begin
                            n_countdown = r_countdown - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= '0;
            r_released   <= '0;
            r_repeating  <= 1'b0;
            r_last_press <= 1'b0;
            r_since      <= '0;
            r_countdown  <= '0;
        end else begin
            r_pressed    <= n_pressed;
            r_released   <= n_released;
            r_repeating  <= n_repeating;
            r_last_press <= n_last_press;
            r_since      <= n_since;
            r_countdown  <= n_countdown;
        end
    end

    srctl_out_buf #(
        .DATA_W (RES_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  ({w_res_action, w_res_keys}),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_data  (w_out_data),
        .i_ready (i_out_ready)
    );

    assign o_out_action = w_out_data[RES_W-1:KEY_BITS];
    assign o_out_keys   = w_out_data[KEY_BITS-1:0];

    `SRC_ASSERT(a_rep_needs_press, i_clk, i_rst_n, !r_repeating || r_last_press, "repeating without a held press")
    `SRC_ASSERT(a_stall_needs_result, i_clk, i_rst_n, o_in_ready || o_out_valid, "input stalled with empty output")
    `SRC_ASSERT_NEXT(a_release_stops, i_clk, i_rst_n, w_accept && (i_opcode == OP_RELEASE), !r_repeating, "release did not stop repeat")
    `SRC_ASSERT_NEXT(a_press_starts, i_clk, i_rst_n, w_accept && (i_opcode == OP_PRESS) && (i_key_state == r_released) && (r_since <= {1'b0, r_forget_span}), r_repeating, "matching press did not start repeat")

endmodule
